FILE: rtl/core/bsri_pkg.sv
package bsri_pkg;

	localparam int COORD_W = 10;
	localparam int SIZE_W  = 11;
	localparam int AREA_W  = 21;
	localparam int CTR_W   = 12;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 21;
	localparam int QUEUE_D = 2;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	localparam logic [1:0] CFG_MIN_SIZE = 2'd0;
	localparam logic [1:0] CFG_X_RES    = 2'd1;
	localparam logic [1:0] CFG_Y_RES    = 2'd2;

	localparam logic [AREA_W-1:0] MIN_SIZE_RST = AREA_W'(0);
	localparam logic [SIZE_W-1:0] X_RES_RST    = SIZE_W'(176);
	localparam logic [SIZE_W-1:0] Y_RES_RST    = SIZE_W'(144);

	typedef enum logic [2:0] {
		K_CLEAR,
		K_INSERT,
		K_IGNORE,
		K_READ,
		K_NOP
	} kind_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] bottom;
		logic [AREA_W-1:0]  area;
		logic [CTR_W-1:0]   x_center;
		logic [CTR_W-1:0]   y_center;
	} entry_t;

	typedef struct packed {
		kind_t              kind;
		entry_t             box;
		logic [IDX_W-1:0]   idx;
	} qitem_t;

endpackage

FILE: rtl/core/bsri_front.sv
module bsri_front
	import bsri_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic [1:0]         operation,
	input  logic [COORD_W-1:0] box_left,
	input  logic [COORD_W-1:0] box_right,
	input  logic [COORD_W-1:0] box_top,
	input  logic [COORD_W-1:0] box_bottom,
	input  logic [IDX_W-1:0]   entry_index,
	output qitem_t             item
);

	logic [AREA_W-1:0] min_size_q;
	logic [SIZE_W-1:0] x_res_q;
	logic [SIZE_W-1:0] y_res_q;

	logic [COORD_W-1:0] dw, dh;
	logic [SIZE_W-1:0]  w, h;
	logic [AREA_W-1:0]  area;
	logic [CTR_W:0]     xs, ys;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q <= MIN_SIZE_RST;
			x_res_q    <= X_RES_RST;
			y_res_q    <= Y_RES_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MIN_SIZE: min_size_q <= cfg_wdata[AREA_W-1:0];
				CFG_X_RES:    x_res_q    <= cfg_wdata[SIZE_W-1:0];
				CFG_Y_RES:    y_res_q    <= cfg_wdata[SIZE_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		dw   = box_right - box_left;
		dh   = box_bottom - box_top;
		w    = {1'b0, dw} + SIZE_W'(1);
		h    = {1'b0, dh} + SIZE_W'(1);
		area = AREA_W'(w) * AREA_W'(h);
		xs   = (CTR_W+1)'(w >> 1) + (CTR_W+1)'(box_left) - (CTR_W+1)'(x_res_q >> 1);
		ys   = (CTR_W+1)'(0) -
		       ((CTR_W+1)'(h >> 1) + (CTR_W+1)'(box_top) - (CTR_W+1)'(y_res_q >> 1));
	end

	always_comb begin
		item.box.left     = box_left;
		item.box.right    = box_right;
		item.box.top      = box_top;
		item.box.bottom   = box_bottom;
		item.box.area     = area;
		item.box.x_center = xs[CTR_W-1:0];
		item.box.y_center = ys[CTR_W-1:0];
		item.idx          = entry_index;
		unique case (operation)
			OP_CLEAR:  item.kind = K_CLEAR;
			OP_INSERT: item.kind = (area < min_size_q) ? K_IGNORE : K_INSERT;
			OP_READ:   item.kind = K_READ;
			default:   item.kind = K_NOP;
		endcase
	end

endmodule

FILE: rtl/core/bsri_queue.sv
module bsri_queue
	import bsri_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t push_item,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output qitem_t head
);

	localparam int PW = $clog2(QUEUE_D);

	qitem_t          slots_q [QUEUE_D];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     fill_q;

	assign full      = (fill_q == (PW+1)'(QUEUE_D));
	assign not_empty = (fill_q != '0);
	assign head      = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_D-1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_D-1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (PW+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (PW+1)'(1);
			end
		end
	end

endmodule

FILE: rtl/core/bsri_table.sv
module bsri_table
	import bsri_pkg::*;
#(
	parameter int MAX_BLOBS = 8
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  qitem_t q_item,
	output logic   q_pop,
	output logic   m_tvalid,
	input  logic   m_tready,
	output logic [1:0]  m_tuser,
	output logic [95:0] m_tdata
);

	localparam int CW = $clog2(MAX_BLOBS + 1);

	entry_t          ent_q [MAX_BLOBS];
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   slot;
	logic [CW-1:0]   cnt_nxt;
	logic            drop;
	logic            store;
	logic            hit;
	entry_t          rd_ent;
	logic [1:0]      st_nxt;
	entry_t          out_nxt;
	logic            m_valid_q;
	logic [1:0]      st_q;
	logic [3:0]      ocnt_q;
	entry_t          oent_q;

	assign q_pop = q_valid && (!m_valid_q || m_tready);

	always_comb begin
		slot = cnt_q;
		for (int i = MAX_BLOBS - 1; i >= 0; i--) begin
			if ((CW'(i) < cnt_q) && (ent_q[i].area < q_item.box.area)) begin
				slot = CW'(i);
			end
		end
		drop  = (slot == CW'(MAX_BLOBS));
		store = q_pop && (q_item.kind == K_INSERT) && !drop;
	end

	always_comb begin
		rd_ent = '0;
		for (int i = 0; i < MAX_BLOBS; i++) begin
			if (int'(q_item.idx) == i) begin
				rd_ent = ent_q[i];
			end
		end
		hit = (int'(q_item.idx) < int'(cnt_q)) && (int'(q_item.idx) < MAX_BLOBS);
	end

	always_comb begin
		cnt_nxt = cnt_q;
		st_nxt  = ST_OK;
		out_nxt = '0;
		unique case (q_item.kind)
			K_CLEAR:  cnt_nxt = '0;
			K_INSERT: begin
				if (drop) begin
					st_nxt = ST_REJECT;
				end else if (cnt_q < CW'(MAX_BLOBS)) begin
					cnt_nxt = cnt_q + CW'(1);
				end
			end
			K_IGNORE: st_nxt = ST_REJECT;
			K_READ: begin
				if (hit) begin
					out_nxt = rd_ent;
				end else begin
					st_nxt = ST_RANGE;
				end
			end
			default:  ;
		endcase
	end

	for (genvar i = 0; i < MAX_BLOBS; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (store) begin
				if (CW'(i) == slot) begin
					ent_q[i] <= q_item.box;
				end else if (CW'(i) > slot) begin
					if (i > 0) begin
						ent_q[i] <= ent_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cnt_q <= cnt_nxt;
			end
			if (q_pop) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			st_q   <= st_nxt;
			ocnt_q <= 4'(cnt_nxt);
			oent_q <= out_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = st_q;
	assign m_tdata  = {7'd0, oent_q.y_center, oent_q.x_center, oent_q.area,
	                   oent_q.bottom, oent_q.top, oent_q.right, oent_q.left, ocnt_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_BLOBS))
		else $error("entry count above table depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_item.kind == K_CLEAR |=> cnt_q == '0)
		else $error("clear left entries behind");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_item.kind == K_INSERT && drop |-> cnt_q == CW'(MAX_BLOBS))
		else $error("insert dropped while table not full");

	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		store && cnt_q < CW'(MAX_BLOBS) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("stored insert did not grow count");

endmodule

FILE: rtl/core/blob_size_ranked_insert_unit.sv
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser operation, tdata box and rank
// m_*       out  m_tvalid/m_tready  tuser status, tdata count and entry
// cfg_*     in   cfg_we             cfg_addr register, cfg_wdata value
//
// one item per cycle sustained while m_tready holds high; the area multiply sits in the
// front stage, the slot search and cell shift in the back; m_tvalid rises once an item
// is in the output register; the two-entry queue and the output register let either side
// stall alone; reset clears the entry count and the queue; stored entries need no clearing
module blob_size_ranked_insert_unit
	import bsri_pkg::*;
#(
	parameter int MAX_BLOBS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [1:0]       s_tuser,   // operation
	input  logic [47:0]      s_tdata,   // box_left, box_right, box_top, box_bottom, entry_index
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [1:0]       m_tuser,   // status
	output logic [95:0]      m_tdata    // entry_count, out_left, out_right, out_top,
	                                    // out_bottom, out_area, out_x_center, out_y_center
);

	qitem_t front_item;
	qitem_t head;
	logic   full;
	logic   not_empty;
	logic   pop;

	assign s_tready = !full;

	bsri_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.operation   (s_tuser),
		.box_left    (s_tdata[9:0]),
		.box_right   (s_tdata[19:10]),
		.box_top     (s_tdata[29:20]),
		.box_bottom  (s_tdata[39:30]),
		.entry_index (s_tdata[42:40]),
		.item        (front_item)
	);

	bsri_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && !full),
		.push_item (front_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	bsri_table #(
		.MAX_BLOBS (MAX_BLOBS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_item   (head),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

endmodule
